/* hw/rtl/bmhr_pkg.sv */
package bmhr_pkg;

  // width of one chain height
  localparam int unsigned H_W = 63;

  // controller states
  typedef enum logic [1:0] {
    ST_FILL,
    ST_SHIFT,
    ST_MED,
    ST_UPD
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic ins;
    logic close_empty;
    logic shift;
    logic med;
    logic upd;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic sh_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/bmhr_ctrl.sv */
module bmhr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_in_batch,
  input  logic               in_empty_batch,
  output logic               in_stall,
  input  bmhr_pkg::dp_stat_t stat,
  output bmhr_pkg::dp_cmd_t  cmd
);

  bmhr_pkg::state_t state_r;
  bmhr_pkg::state_t state_nxt;
  logic             acc;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhr_pkg::ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // only the fill state takes beats
  assign in_stall = (state_r != bmhr_pkg::ST_FILL);
  assign acc      = in_valid && (state_r == bmhr_pkg::ST_FILL);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      bmhr_pkg::ST_FILL: begin
        if (acc) begin
          if (in_empty_batch) begin
            if (stat.cnt_zero) begin
              cmd.close_empty = 1'b1;
            end else begin
              state_nxt = bmhr_pkg::ST_SHIFT;
            end
          end else begin
            cmd.ins = 1'b1;
            if (in_last_in_batch) begin
              state_nxt = bmhr_pkg::ST_SHIFT;
            end
          end
        end
      end
      bmhr_pkg::ST_SHIFT: begin
        if (stat.sh_done) begin
          state_nxt = bmhr_pkg::ST_MED;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      bmhr_pkg::ST_MED: begin
        cmd.med   = 1'b1;
        state_nxt = bmhr_pkg::ST_UPD;
      end
      bmhr_pkg::ST_UPD: begin
        if (stat.out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = bmhr_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = bmhr_pkg::ST_FILL;
      end
    endcase
  end

  // no beat is taken outside the fill state
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins || cmd.close_empty) |-> (state_r == bmhr_pkg::ST_FILL))
    else $error("beat taken while busy");
  // the median step always leads on to the update step
  a_med_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.med |=> (state_r == bmhr_pkg::ST_UPD))
    else $error("median not followed by update");
  // shifting stops once the middle is reached
  a_shift_stop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> !stat.sh_done)
    else $error("shift past middle");

endmodule

/* hw/rtl/bmhr_dp.sv */
module bmhr_dp #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bmhr_pkg::H_W-1:0]   in_height,
  input  bmhr_pkg::dp_cmd_t          cmd,
  output bmhr_pkg::dp_stat_t         stat,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bmhr_pkg::H_W-1:0]   out_median_height,
  output logic [bmhr_pkg::H_W-1:0]   out_network_height,
  output logic                       out_raised,
  output logic                       out_overflowed
);

  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned HW = bmhr_pkg::H_W;

  logic [HW-1:0]    e_r [MAX_NODES];
  logic [MAX_NODES-1:0] gt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    sh_r;
  logic             drop_r;
  logic             room;
  logic [CW-1:0]    cnt_m1;
  logic [HW-1:0]    mid_hi;
  logic [HW:0]      mid_sum;
  logic [HW-1:0]    med_r;
  logic [HW-1:0]    net_r;
  logic             raise;
  logic             out_valid_r;
  logic [HW-1:0]    out_med_r;
  logic [HW-1:0]    out_net_r;
  logic             out_raised_r;
  logic             out_ovf_r;

  assign room   = (cnt_r != CW'(MAX_NODES));
  assign cnt_m1 = cnt_r - CW'(1);

  // sorted insertion chain, one cell per entry
  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic          lt;
    logic [HW-1:0] src;
    logic [HW-1:0] up;

    assign lt    = (IDX < cnt_r);
    assign gt[i] = lt && (e_r[i] > in_height);

    if (i == 0) begin : g_first
      assign src = in_height;
    end else begin : g_rest
      assign src = gt[i-1] ? e_r[i-1] : in_height;
    end

    if (i == MAX_NODES - 1) begin : g_top
      assign up = e_r[i];
    end else begin : g_mid
      assign up = e_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.ins && room) begin
        if (!(lt && !gt[i]) && (IDX <= cnt_r)) begin
          e_r[i] <= src;
        end
      end else if (cmd.shift) begin
        e_r[i] <= up;
      end
    end
  end

  // upper middle entry sits next to the bottom after shifting
  if (MAX_NODES > 1) begin : g_hi
    assign mid_hi = e_r[1];
  end else begin : g_lo
    assign mid_hi = e_r[0];
  end

  assign mid_sum = {1'b0, e_r[0]} + {1'b0, mid_hi};

  // count, drop flag and shift counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
      sh_r   <= '0;
    end else begin
      if (cmd.ins) begin
        if (room) begin
          cnt_r <= cnt_r + CW'(1);
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.shift) begin
        sh_r <= sh_r + CW'(1);
      end
      if (cmd.close_empty || cmd.upd) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
        sh_r   <= '0;
      end
    end
  end

  // median: the bottom entry for an odd count, else the mean of the two bottom entries
  always_ff @(posedge clk) begin
    if (cmd.med) begin
      med_r <= cnt_r[0] ? e_r[0] : mid_sum[HW:1];
    end
  end

  assign raise = (med_r > net_r);

  // network height ratchet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_r <= '0;
    end else if (cmd.upd && raise) begin
      net_r <= med_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_med_r    <= med_r;
      out_net_r    <= raise ? med_r : net_r;
      out_raised_r <= raise;
      out_ovf_r    <= drop_r;
    end
  end

  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.sh_done  = (sh_r == (cnt_m1 >> 1));
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_median_height  = out_med_r;
  assign out_network_height = out_net_r;
  assign out_raised         = out_raised_r;
  assign out_overflowed     = out_ovf_r;

  // store never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_NODES))
    else $error("count above capacity");
  // a result is loaded only into a free output register
  a_upd_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> stat.out_free)
    else $error("result overwrites pending beat");
  // network height never falls
  a_ratchet: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> net_r >= $past(net_r))
    else $error("network height fell");
  // batch state is clear after a result
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> (cnt_r == '0) && !drop_r)
    else $error("batch state not cleared");

endmodule

/* hw/rtl/batch_median_height_ratchet.sv */
// Batch median height ratchet. Chain heights arrive one beat at a time and are
// inserted into a sorted register chain. When a batch closes (last_in_batch,
// or empty_batch after heights), the chain is shifted toward entry zero until
// the middle height (the lower one for an even count) sits there; the shift
// state then sees the shift count reached, the median state forms the median
// and the update state updates the network height and loads the output
// register. No new beat is taken until then, and the update also waits for a
// still pending result. Heights beyond MAX_NODES in one batch are dropped and
// reported through out_overflowed. An empty batch with no heights gives no
// result.
module batch_median_height_ratchet #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [bmhr_pkg::H_W-1:0] in_height,
  input  logic                     in_last_in_batch,
  input  logic                     in_empty_batch,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [bmhr_pkg::H_W-1:0] out_median_height,
  output logic [bmhr_pkg::H_W-1:0] out_network_height,
  output logic                     out_raised,
  output logic                     out_overflowed
);

  bmhr_pkg::dp_cmd_t  cmd;
  bmhr_pkg::dp_stat_t stat;

  // sequencing of insert, shift, median and update
  bmhr_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_last_in_batch (in_last_in_batch),
    .in_empty_batch   (in_empty_batch),
    .in_stall         (in_stall),
    .stat             (stat),
    .cmd              (cmd)
  );

  // sorted chain, median and network height
  bmhr_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_height          (in_height),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_median_height  (out_median_height),
    .out_network_height (out_network_height),
    .out_raised         (out_raised),
    .out_overflowed     (out_overflowed)
  );

endmodule

/* tb/batch_median_height_ratchet_tb.sv */
module batch_median_height_ratchet_tb;

  localparam int unsigned H_W = bmhr_pkg::H_W;
  localparam int unsigned MAX_NODES = 16;
  localparam int unsigned LIMIT = 500000;
  localparam int unsigned RANDOM_BEATS = 1250;
  localparam logic [H_W-1:0] H_MAX = '1;

  // one input beat
  typedef struct packed {
    logic [H_W-1:0] height;
    logic           last;
    logic           empty;
  } height_beat_t;

  // one result beat
  typedef struct packed {
    logic [H_W-1:0] median;
    logic [H_W-1:0] network;
    logic           raised;
    logic           overflowed;
  } median_res_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [H_W-1:0] in_height = '0;
  logic           in_last_in_batch = 1'b0;
  logic           in_empty_batch = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [H_W-1:0] out_median_height;
  logic [H_W-1:0] out_network_height;
  logic           out_raised;
  logic           out_overflowed;

  batch_median_height_ratchet #(
    .MAX_NODES(MAX_NODES)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_height         (in_height),
    .in_last_in_batch  (in_last_in_batch),
    .in_empty_batch    (in_empty_batch),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_median_height (out_median_height),
    .out_network_height(out_network_height),
    .out_raised        (out_raised),
    .out_overflowed    (out_overflowed)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  height_beat_t   height_q[$];
  median_res_t    pending_medians[$];
  int             beats_queued = 0;
  int             beats_in = 0;
  int             medians_checked = 0;
  int             raised_seen = 0;
  int             ovf_seen = 0;
  int             errs = 0;
  int             cycles = 0;
  bit             src_idle = 1'b1;
  bit             snk_idle = 1'b1;
  logic           in_taken = 1'b0;

  // predictor state: sorted batch, its fill, drop flag and ratchet
  logic [H_W-1:0] chain_hts[MAX_NODES];
  int             chain_n = 0;
  logic           chain_drop = 1'b0;
  logic [H_W-1:0] net_height = '0;

  // idle length: mostly none, often short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [H_W-1:0] wild_height();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[H_W-1:0];
  endfunction

  // insert one height into the sorted batch; close the batch on last or empty
  task automatic ratchet_take(input height_beat_t b, output bit got, output median_res_t r);
    logic [H_W:0] pair_sum;
    int k;
    got = 1'b0;
    r = '0;
    if (!b.empty) begin
      if (chain_n < MAX_NODES) begin
        k = chain_n;
        while (k > 0 && chain_hts[k-1] > b.height) begin
          chain_hts[k] = chain_hts[k-1];
          k--;
        end
        chain_hts[k] = b.height;
        chain_n++;
      end else begin
        chain_drop = 1'b1;
      end
    end
    if (b.empty || b.last) begin
      if (chain_n > 0) begin
        if (chain_n % 2 == 1) begin
          r.median = chain_hts[chain_n/2];
        end else begin
          pair_sum = {1'b0, chain_hts[chain_n/2-1]} + {1'b0, chain_hts[chain_n/2]};
          r.median = pair_sum[H_W:1];
        end
        if (r.median > net_height) begin
          net_height = r.median;
          r.raised = 1'b1;
        end
        r.network = net_height;
        r.overflowed = chain_drop;
        got = 1'b1;
      end
      chain_n = 0;
      chain_drop = 1'b0;
    end
  endtask

  function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errs++;
    end
  endfunction

  // driver: next beat on the falling edge once the current one is taken
  always @(negedge clk) begin : driver
    height_beat_t b;
    int src_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else if (!in_valid || in_taken) begin
      if (src_gap > 0) begin
        in_valid <= 1'b0;
        src_gap--;
      end else if (height_q.size() > 0) begin
        b = height_q.pop_front();
        in_valid <= 1'b1;
        in_height <= b.height;
        in_last_in_batch <= b.last;
        in_empty_batch <= b.empty;
        src_gap = src_idle ? gap_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin : sink
    int snk_gap;
    if (snk_idle && snk_gap > 0) begin
      out_stall <= 1'b1;
      snk_gap--;
    end else begin
      out_stall <= 1'b0;
      snk_gap = snk_idle ? gap_len() : 0;
    end
  end

  // monitor: check result beats, then predict from the accepted input beat
  always @(posedge clk) begin : monitor
    height_beat_t b;
    median_res_t exp_r;
    median_res_t new_r;
    bit got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (pending_medians.size() == 0) begin
          $error("result beat with no batch pending: median %0d", out_median_height);
          errs++;
        end else begin
          exp_r = pending_medians.pop_front();
          check_field("median_height", 64'(exp_r.median), 64'(out_median_height));
          check_field("network_height", 64'(exp_r.network), 64'(out_network_height));
          check_field("raised", 64'(exp_r.raised), 64'(out_raised));
          check_field("overflowed", 64'(exp_r.overflowed), 64'(out_overflowed));
          medians_checked++;
          raised_seen += int'(exp_r.raised);
          ovf_seen += int'(exp_r.overflowed);
        end
      end
      if (in_valid && !in_stall) begin
        b.height = in_height;
        b.last = in_last_in_batch;
        b.empty = in_empty_batch;
        ratchet_take(b, got, new_r);
        if (got) pending_medians = {pending_medians, new_r};
        beats_in++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  logic [H_W-1:0] tip = 63'd1000;
  int             random_beats = 0;

  task automatic send_beat(input logic [H_W-1:0] h, input logic last, input logic empty);
    height_beat_t b;
    b.height = h;
    b.last = last;
    b.empty = empty;
    height_q = {height_q, b};
    beats_queued++;
  endtask

  // heights cluster near a slowly rising tip; big batches may carry wild outliers
  function automatic logic [H_W-1:0] pick_height(bit wild_ok);
    int r;
    r = $urandom_range(0, 99);
    if (wild_ok && r < 5) return wild_height();
    if (wild_ok && r < 7) return '0;
    if (r < 10) return H_W'($urandom_range(0, 60));
    return tip - H_W'($urandom_range(0, 40)) + H_W'($urandom_range(0, 8));
  endfunction

  // n heights closed by last, or by an empty marker
  task automatic send_batch(input int n, input bit by_marker);
    for (int i = 0; i < n; i++) begin
      send_beat(pick_height(n >= 5), (i == n - 1) && !by_marker, 1'b0);
    end
    if (by_marker) send_beat(wild_height(), 1'($urandom_range(0, 1)), 1'b1);
    tip = tip + H_W'($urandom_range(0, 12));
  endtask

  // hold the sender until every result so far has arrived
  task automatic drain();
    while (beats_in != beats_queued || pending_medians.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int n;
    int r;
    bit by_marker;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // lone empty batch gives nothing
    send_beat(H_MAX, 1'b1, 1'b1);
    // single zero, then an even pair rounding down
    send_beat('0, 1'b1, 1'b0);
    send_beat(63'd3, 1'b0, 1'b0);
    send_beat(63'd8, 1'b1, 1'b0);
    // extremes as outliers around a middle value
    send_beat(H_MAX, 1'b0, 1'b0);
    send_beat('0, 1'b0, 1'b0);
    send_beat(63'd1, 1'b1, 1'b0);
    // empty marker wins over last and closes a pair
    send_beat(63'd20, 1'b0, 1'b0);
    send_beat(63'd10, 1'b0, 1'b0);
    send_beat(H_MAX, 1'b1, 1'b1);
    send_beat(63'd30, 1'b0, 1'b0);
    send_beat('0, 1'b0, 1'b1);
    // full store: seventeenth height is dropped but still ends the batch
    for (int i = 0; i < 17; i++) send_beat(63'd200 - H_W'(i), i == 16, 1'b0);
    drain();

    // random batches in chunks, each chunk with its own idling mix
    while (random_beats < RANDOM_BEATS) begin
      src_idle = 1'($urandom_range(0, 1));
      snk_idle = 1'($urandom_range(0, 1));
      repeat (8) begin
        r = $urandom_range(0, 99);
        if (r < 8) n = $urandom_range(17, 20);
        else if (r < 16) n = MAX_NODES;
        else n = $urandom_range(1, 15);
        by_marker = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 19) == 0) begin
          send_beat(wild_height(), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
          send_batch(n, by_marker);
          random_beats += n + by_marker;
        end
      end
      while (height_q.size() > 0) @(posedge clk);
      if ($urandom_range(0, 3) == 0) drain();
    end

    // saturate the ratchet last: carry out of the pair sum, then the top height
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_beat(H_MAX - 63'd1, 1'b0, 1'b0);
    send_beat(H_MAX, 1'b1, 1'b0);
    send_beat(H_MAX, 1'b1, 1'b0);

    drain();
    repeat (40) @(posedge clk);
    $display("tb: %0d height beats taken, %0d medians checked", beats_in, medians_checked);
    $display("tb: %0d batches raised the network height, %0d overflowed", raised_seen,
             ovf_seen);
    if (errs == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bmhr_pkg.sv
hw/rtl/bmhr_ctrl.sv
hw/rtl/bmhr_dp.sv
hw/rtl/batch_median_height_ratchet.sv
tb/batch_median_height_ratchet_tb.sv
